>>> rtl/mhb_pkg.sv
`default_nettype none
package mhb_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int N_W      = IDX_W + 1;
  localparam int KID_W    = IDX_W + 2;

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [N_W-1:0]    cnt_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // write accepted item into the store
    logic get_node;  // latch parent value, fetch its children
    logic step;      // one sift-down compare and move
    logic emit;      // read port follows the emit pointer
    logic emit_ld;   // load the output register
  } mhb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic fin;        // current input item closes the run
    logic n_one;      // run holds a single element
    logic sift_done;  // node is no smaller than its children
    logic k_zero;     // root is the current parent
    logic emit_last;  // emit pointer at the final element
    logic out_free;   // output register can take a new item
  } mhb_sts_t;

endpackage
`default_nettype wire

>>> rtl/max_heap_builder.sv
`default_nettype none
// Load: one item per cycle into a 64-entry store; the closing item (in_tlast or the 64th)
//   starts the build, or the emit for a one-element run. Build: a read, then per parent a fetch
//   and one sift-down step per level it sinks plus a final compare, against a two-read-port store.
// Emit reads, then loads each element, and stalls while the output register is full;
//   a new run may load while the final result still waits in the output register.
// Reset (rst_n low, synchronous) empties the run and the output register; store contents stay.
module max_heap_builder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] value_res
  output logic             out_tlast
);
  import mhb_pkg::*;

  mhb_cmd_t cmd;
  mhb_sts_t sts;
  data_t    out_value;

  mhb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mhb_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_value   (in_tdata),
    .in_last    (in_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_value  (out_value),
    .out_last   (out_tlast)
  );

  assign out_tdata = out_value;

endmodule
`default_nettype wire

>>> rtl/mhb_ctrl.sv
`default_nettype none
module mhb_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire mhb_pkg::mhb_sts_t sts,
  output mhb_pkg::mhb_cmd_t     cmd
);
  import mhb_pkg::*;

  localparam logic [2:0] S_LOAD    = 3'd0;
  localparam logic [2:0] S_RDNODE  = 3'd1;
  localparam logic [2:0] S_GETNODE = 3'd2;
  localparam logic [2:0] S_CMP     = 3'd3;
  localparam logic [2:0] S_EMIT_RD = 3'd4;
  localparam logic [2:0] S_EMIT_LD = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_tready    = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
        if (in_tvalid && sts.fin) begin
          state_nxt = sts.n_one ? S_EMIT_RD : S_RDNODE;
        end
      end
      S_RDNODE: begin
        state_nxt = S_GETNODE;
      end
      S_GETNODE: begin
        cmd.get_node = 1'b1;
        state_nxt    = S_CMP;
      end
      S_CMP: begin
        cmd.step = 1'b1;
        if (sts.sift_done) begin
          // next parent's read is issued in this cycle
          state_nxt = sts.k_zero ? S_EMIT_RD : S_GETNODE;
        end
      end
      S_EMIT_RD: begin
        cmd.emit  = 1'b1;
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cmd.emit = 1'b1;
        if (sts.out_free) begin
          cmd.emit_ld = 1'b1;
          state_nxt   = sts.emit_last ? S_LOAD : S_EMIT_RD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/mhb_dp.sv
`default_nettype none
module mhb_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mhb_pkg::data_t    in_value,
  input  wire logic              in_last,
  input  wire mhb_pkg::mhb_cmd_t cmd,
  output mhb_pkg::mhb_sts_t      sts,
  input  wire logic              out_tready,
  output logic                   out_tvalid,
  output mhb_pkg::data_t         out_value,
  output logic                   out_last
);
  import mhb_pkg::*;

  data_t mem [CAPACITY];

  idx_t  count_r, count_nxt;
  cnt_t  n_r, n_nxt;
  idx_t  k_r, k_nxt;
  idx_t  node_r, node_nxt;
  idx_t  e_r, e_nxt;
  data_t cur_r;
  data_t rda_r, rdb_r;
  data_t out_data_r;
  logic  out_last_r;
  logic  out_valid_r, out_valid_nxt;

  logic [KID_W-1:0] lc, rc, base_lc, n_ext;
  idx_t  base, addr_a, addr_b, wr_addr;
  data_t wr_data, big_val, lbig_val;
  logic  wr_en, gt_l, gt_r, done;
  idx_t  big_idx;
  logic  last_e;

  // compare against the children of the node being sifted
  always_comb begin
    n_ext    = {1'b0, n_r};
    lc       = {1'b0, node_r, 1'b1};
    rc       = lc + KID_W'(1);
    gt_l     = (lc < n_ext) && ($signed(rda_r) > $signed(cur_r));
    lbig_val = gt_l ? rda_r : cur_r;
    gt_r     = (rc < n_ext) && ($signed(rdb_r) > $signed(lbig_val));
    done     = !gt_l && !gt_r;
    big_idx  = gt_r ? rc[IDX_W-1:0] : lc[IDX_W-1:0];
    big_val  = gt_r ? rdb_r : rda_r;
  end

  // read addresses
  always_comb begin
    base    = cmd.get_node ? k_r : big_idx;
    base_lc = {1'b0, base, 1'b1};
    addr_a  = k_r;
    addr_b  = base_lc[IDX_W-1:0] + IDX_W'(1);
    if (cmd.emit) begin
      addr_a = e_r;
    end else if (cmd.get_node || (cmd.step && !done)) begin
      addr_a = base_lc[IDX_W-1:0];
    end else if (cmd.step && done) begin
      addr_a = k_r - IDX_W'(1);
    end
  end

  // single write port
  always_comb begin
    wr_en   = cmd.load || cmd.step;
    wr_addr = cmd.load ? count_r : node_r;
    wr_data = cmd.load ? in_value : (done ? cur_r : big_val);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rda_r <= mem[addr_a];
    rdb_r <= mem[addr_b];
  end

  assign last_e = ({1'b0, e_r} == (n_r - N_W'(1)));

  always_comb begin
    sts.fin       = in_last || (count_r == IDX_W'(CAPACITY - 1));
    sts.n_one     = (count_r == '0);
    sts.sift_done = done;
    sts.k_zero    = (k_r == '0);
    sts.emit_last = last_e;
    sts.out_free  = !out_valid_r || out_tready;
  end

  always_comb begin
    count_nxt     = count_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    node_nxt      = node_r;
    e_nxt         = e_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load) begin
      if (sts.fin) begin
        count_nxt = '0;
        n_nxt     = {1'b0, count_r} + N_W'(1);
        k_nxt     = (count_r - IDX_W'(1)) >> 1;
        e_nxt     = '0;
      end else begin
        count_nxt = count_r + IDX_W'(1);
      end
    end
    if (cmd.get_node) begin
      node_nxt = k_r;
    end
    if (cmd.step) begin
      if (done) begin
        k_nxt = k_r - IDX_W'(1);
      end else begin
        node_nxt = big_idx;
      end
    end
    if (cmd.emit_ld) begin
      out_valid_nxt = 1'b1;
      e_nxt         = e_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    k_r    <= k_nxt;
    node_r <= node_nxt;
    e_r    <= e_nxt;
    if (cmd.get_node) begin
      cur_r <= rda_r;
    end
    if (cmd.emit_ld) begin
      out_data_r <= rda_r;
      out_last_r <= last_e;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_value  = out_data_r;
  assign out_last   = out_last_r;

endmodule
`default_nettype wire
